>>> hw/rtl/pfba_pkg.sv
// Shared constants, command codes and types for the page frame bitmap allocator.
`timescale 1ns / 1ps

package pfba_pkg;

  // Default map geometry
  localparam int MAP_BYTES_DEF  = 4096;
  localparam int PAGE_SHIFT_DEF = 12;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int ADDR64_W = 64;
  localparam int QPAGE_W = 15;
  localparam int COUNT_W = 16;

  // Packed stream widths
  localparam int S_DATA_W = 144;
  localparam int M_DATA_W = 40;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
  localparam logic [7:0]         BYTE_FULL = 8'hFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_FREE  = 2'd0,
    CMD_CLAIM = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } pfba_cmd_t;

  // Result of updating one map byte
  typedef struct packed {
    logic [7:0] new_byte;  // byte to write back
    logic       hit;       // claim met an occupied page in this byte
    logic [2:0] hit_bit;   // bit position of that page
    logic [3:0] n_pages;   // pages of the range in this byte
  } pfba_upd_t;

endpackage

>>> hw/rtl/pfba_map_ram.sv
// Occupancy map storage: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module pfba_map_ram
  import pfba_pkg::*;
#(
  parameter int DEPTH  = MAP_BYTES_DEF,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/pfba_byte_update.sv
// Modify one map byte for a free or claim walk over pages lo up to hi (exclusive).
`timescale 1ns / 1ps

module pfba_byte_update
  import pfba_pkg::*;
(
  input  logic [7:0] data,
  input  logic [2:0] lo,
  input  logic [3:0] hi,
  input  logic       claim,
  output pfba_upd_t  upd
);

  logic [7:0] mask;
  logic [7:0] occ;
  logic [7:0] below;
  logic       found;
  logic [2:0] first_bit;
  logic [3:0] cnt;

  // Build the mask of pages inside the range
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mask[b] = (4'(b) >= {1'b0, lo}) && (4'(b) < hi);
    end
  end

  // Find the lowest occupied page of the range and count pages
  always_comb begin
    occ       = data & mask;
    found     = 1'b0;
    first_bit = 3'd0;
    below     = 8'hFF;
    cnt       = 4'd0;
    for (int b = 0; b < 8; b++) begin
      cnt = cnt + 4'(mask[b]);
    end
    for (int b = 7; b >= 0; b--) begin
      if (occ[b]) begin
        found     = 1'b1;
        first_bit = 3'(b);
      end
    end
    if (found) begin
      below = (8'd1 << first_bit) - 8'd1;
    end
  end

  // Select the written byte
  always_comb begin
    upd.hit     = claim && found;
    upd.hit_bit = first_bit;
    upd.n_pages = cnt;
    if (claim) begin
      upd.new_byte = data | (mask & below);
    end else begin
      upd.new_byte = data & ~mask;
    end
  end

endmodule

>>> hw/rtl/page_frame_bitmap_allocator.sv
// Flow: a query reads the map byte of its page; a range command does a read-modify-write of every
// map byte that the range touches, and a claim stops at its first occupied page.
// Throughput: one command at a time; the next is taken once the current result is registered.
// Reset: synchronous, active high; afterwards a clearing pass marks every
// page occupied and no command is taken until it ends. The free count resets to zero.
`timescale 1ns / 1ps

module page_frame_bitmap_allocator
  import pfba_pkg::*;
#(
  parameter int MAP_BYTES  = MAP_BYTES_DEF,
  parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // region_available[0], range_base[64:1], range_limit[128:65], page_number[143:129]
  input  logic [S_DATA_W-1:0] s_tdata,
  // command[1:0]
  input  logic [CMD_W-1:0]    s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // ok[0], page_free[1], free_count[17:2], conflict_page[32:18], zero[39:33]
  output logic [M_DATA_W-1:0] m_tdata
);

  localparam int ADDR_W = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int CNT_W  = ADDR_W + 1;
  localparam logic [63:0] PAGE_LIMIT = 64'(MAP_BYTES) * 64'd8;
  localparam logic [63:0] OFF_MASK   = (64'd1 << PAGE_SHIFT) - 64'd1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_BYTES - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_CHECK,
    S_RD,
    S_MOD,
    S_QANS,
    S_DONE
  } state_t;

  state_t state;

  // Captured command
  pfba_cmd_t           cmd;
  logic                avail;
  logic [ADDR64_W-1:0] range_base;
  logic [ADDR64_W-1:0] range_limit;
  logic [QPAGE_W-1:0]  qpage;

  // Walk state
  logic [63:0]       first_pg;
  logic [63:0]       stop_pg;
  logic [ADDR_W-1:0] cur_byte;
  logic [2:0]        cur_bit;
  logic [CNT_W-1:0]  stop_byte;
  logic [2:0]        stop_bit;
  logic [ADDR_W-1:0] clr_addr;

  // Result
  logic [COUNT_W-1:0] free_pages;
  logic               res_ok;
  logic               res_free;
  logic [QPAGE_W-1:0] res_conflict;

  // Memory ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  // Datapath helpers
  logic [63:0]        first_calc;
  logic [63:0]        end_pg;
  logic [63:0]        stop_calc;
  logic [63:0]        q64;
  logic [ADDR_W-1:0]  q_addr;
  logic               q_in_range;
  logic [CNT_W-1:0]   cur_ext;
  logic [CNT_W-1:0]   cur_inc;
  logic               at_stop_byte;
  logic               last_byte;
  logic [3:0]         hi;
  logic [63:0]        hit_page;
  logic [COUNT_W:0]   count_sum;
  pfba_upd_t          upd;

  // Round the range to whole pages and clamp to the map
  always_comb begin
    first_calc = (range_base >> PAGE_SHIFT) + 64'(|(range_base & OFF_MASK));
    end_pg     = range_limit >> PAGE_SHIFT;
    stop_calc  = (end_pg > PAGE_LIMIT) ? PAGE_LIMIT : end_pg;
  end

  // Locate the queried page
  always_comb begin
    q64        = {{(64-QPAGE_W){1'b0}}, qpage};
    q_addr     = q64[ADDR_W+2:3];
    q_in_range = q64 < PAGE_LIMIT;
  end

  // Bound the current byte of the walk
  always_comb begin
    cur_ext      = {1'b0, cur_byte};
    cur_inc      = cur_ext + CNT_W'(1);
    at_stop_byte = (cur_ext == stop_byte);
    last_byte    = at_stop_byte || ((cur_inc == stop_byte) && (stop_bit == 3'd0));
    hi           = at_stop_byte ? {1'b0, stop_bit} : 4'd8;
    hit_page     = ({{(64-ADDR_W){1'b0}}, cur_byte} << 3) | {61'd0, upd.hit_bit};
    count_sum    = {1'b0, free_pages} + {{(COUNT_W-3){1'b0}}, upd.n_pages};
  end

  pfba_byte_update u_upd (
    .data  (ram_rdata),
    .lo    (cur_bit),
    .hi    (hi),
    .claim (cmd == CMD_CLAIM),
    .upd   (upd)
  );

  // Drive the memory ports
  always_comb begin
    ram_raddr = (state == S_PREP) ? q_addr : cur_byte;
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = BYTE_FULL;
    end else begin
      ram_we    = (state == S_MOD);
      ram_waddr = cur_byte;
      ram_wdata = upd.new_byte;
    end
  end

  pfba_map_ram #(
    .DEPTH  (MAP_BYTES),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign s_tready = (state == S_IDLE);

  // Sequence commands and hold the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      free_pages <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      // drop the result after its transfer unless a new one is loaded
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            cmd          <= pfba_cmd_t'(s_tuser);
            avail        <= s_tdata[0];
            range_base   <= s_tdata[64:1];
            range_limit  <= s_tdata[128:65];
            qpage        <= s_tdata[143:129];
            res_ok       <= 1'b1;
            res_free     <= 1'b0;
            res_conflict <= '0;
            state        <= S_PREP;
          end
        end
        S_PREP: begin
          first_pg <= first_calc;
          stop_pg  <= stop_calc;
          case (cmd)
            CMD_FREE: state  <= avail ? S_CHECK : S_DONE;
            CMD_CLAIM: state <= S_CHECK;
            CMD_QUERY: state <= S_QANS;
            default: state   <= S_DONE;
          endcase
        end
        S_CHECK: begin
          cur_byte  <= first_pg[ADDR_W+2:3];
          cur_bit   <= first_pg[2:0];
          stop_byte <= stop_pg[ADDR_W+3:3];
          stop_bit  <= stop_pg[2:0];
          state     <= (first_pg < stop_pg) ? S_RD : S_DONE;
        end
        S_RD: begin
          state <= S_MOD;
        end
        S_MOD: begin
          if (cmd == CMD_FREE) begin
            free_pages <= count_sum[COUNT_W] ? COUNT_MAX : count_sum[COUNT_W-1:0];
          end
          cur_byte <= cur_inc[ADDR_W-1:0];
          cur_bit  <= 3'd0;
          if (upd.hit) begin
            res_ok       <= 1'b0;
            res_conflict <= hit_page[QPAGE_W-1:0];
            state        <= S_DONE;
          end else if (last_byte) begin
            state <= S_DONE;
          end else begin
            state <= S_RD;
          end
        end
        S_QANS: begin
          res_free <= q_in_range && !ram_rdata[q64[2:0]];
          state    <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'd0, res_conflict, free_pages, res_free, res_ok};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
